// ===== sv/sgcm_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the stick to gimbal
// command mapper. No dependencies; sgcm_if and the top level import this.
`timescale 1ns / 1ps
`default_nettype none

package sgcm_pkg;

	localparam int AXIS_W      = 11;
	localparam int BTN_W       = 5;
	localparam int ANGLE_W     = 16;
	localparam int ZOOM_W      = 4;
	localparam int DZ_W        = 10;
	localparam int ZOOM_CODE_W = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int GAIN_DEF            = 4;
	localparam int AXIS_FULL_SCALE_DEF = 1000;
	// largest magnitude an 11-bit signed axis can carry
	localparam int AXIS_MAG_MAX        = 1024;

	// button bit positions in the packed button word
	localparam int BTN_SAVE      = 0;
	localparam int BTN_STABILIZE = 1;
	localparam int BTN_ZOOM_DOWN = 2;
	localparam int BTN_ZOOM_UP   = 3;
	localparam int BTN_CENTER    = 4;

	localparam logic [DZ_W-1:0]        DEADZONE_RST   = DZ_W'(200);
	localparam logic [ANGLE_W-1:0]     CENTER_RST     = ANGLE_W'(3000);
	localparam logic [ANGLE_W-1:0]     ANGLE_LO_RST   = '0;
	localparam logic [ANGLE_W-1:0]     ANGLE_HI_RST   = '1;
	localparam logic [ZOOM_W-1:0]      ZOOM_MIN_RST   = ZOOM_W'(1);
	localparam logic [ZOOM_W-1:0]      ZOOM_MAX_RST   = ZOOM_W'(9);
	localparam logic [ZOOM_CODE_W-1:0] ZOOM_NONE_CODE = 32'hAAAA_AAAA;

	// curve constants: ln 4 and 1.0 in Q4.28, series length, output scale
	localparam longint unsigned LN4_Q28     = 64'd372130559;
	localparam longint unsigned ONE_Q28     = 64'd268435456;
	localparam longint unsigned CURVE_SCALE = 64'd40;
	localparam int              CURVE_TERMS = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADZONE,
		CFG_CENTER_ANGLE,
		CFG_ROLL_MIN,
		CFG_ROLL_MAX,
		CFG_PITCH_MIN,
		CFG_PITCH_MAX,
		CFG_ZOOM_MIN,
		CFG_ZOOM_MAX
	} cfg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] roll;
		logic [ANGLE_W-1:0] pitch;
		logic [ZOOM_W-1:0]  zoom;
		logic [BTN_W-1:0]   btn;
	} state_t;

	localparam state_t STATE_RST = '{
		roll:  CENTER_RST,
		pitch: CENTER_RST,
		zoom:  ZOOM_MIN_RST,
		btn:   '0
	};

	// shift and subtract quotient, build time only
	function automatic longint unsigned udiv_f(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r    = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Taylor series of e^x - 1 in Q28, truncating each term; build time only
	function automatic longint unsigned curve_sum_f(longint unsigned x);
		longint unsigned term;
		longint unsigned sum;
		term = x;
		sum  = x;
		for (int n = 2; n <= CURVE_TERMS; n++) begin
			term = udiv_f(term * x, longint'(n) * ONE_Q28);
			sum  = sum + term;
		end
		return sum;
	endfunction

	function automatic logic [ZOOM_CODE_W-1:0] zoom_word_f(logic [ZOOM_W-1:0] lvl);
		logic [ZOOM_CODE_W-1:0] w;
		unique case (lvl)
			4'd1:    w = 32'h0000_0000;
			4'd2:    w = 32'h0008_0000;
			4'd3:    w = 32'h0100_0000;
			4'd4:    w = 32'h0108_0000;
			4'd5:    w = 32'h0200_0000;
			4'd6:    w = 32'h0208_0000;
			4'd7:    w = 32'h0300_0000;
			4'd8:    w = 32'h0308_0000;
			4'd9:    w = 32'h0400_0000;
			default: w = ZOOM_NONE_CODE;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== sv/sgcm_if.sv =====
// Valid/ready channel interfaces for stick polls and command results.
// Depends on sgcm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sgcm_in_if;
	import sgcm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [AXIS_W-1:0] stick_x;
	logic signed [AXIS_W-1:0] stick_y;
	logic                     btn_save;
	logic                     btn_stabilize;
	logic                     btn_zoom_down;
	logic                     btn_zoom_up;
	logic                     btn_center;

	modport source (
		output valid, stick_x, stick_y, btn_save, btn_stabilize, btn_zoom_down,
			btn_zoom_up, btn_center,
		input  ready
	);
	modport sink (
		input  valid, stick_x, stick_y, btn_save, btn_stabilize, btn_zoom_down,
			btn_zoom_up, btn_center,
		output ready
	);
endinterface

interface sgcm_out_if;
	import sgcm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   gimbal_update;
	logic [ANGLE_W-1:0]     roll_cmd;
	logic [ANGLE_W-1:0]     pitch_cmd;
	logic                   zoom_update;
	logic [ZOOM_CODE_W-1:0] zoom_code;
	logic                   save_pulse;
	logic                   stabilize_pulse;

	modport source (
		output valid, gimbal_update, roll_cmd, pitch_cmd, zoom_update, zoom_code,
			save_pulse, stabilize_pulse,
		input  ready
	);
	modport sink (
		input  valid, gimbal_update, roll_cmd, pitch_cmd, zoom_update, zoom_code,
			save_pulse, stabilize_pulse,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/stick_to_gimbal_command_mapper.sv =====
// Stick to gimbal command mapper, top level.
// Depends on sgcm_pkg, sgcm_if (channels) and sgcm_ram (state store).
//
// Usage:
//   stick_in carries one poll per transfer: two signed 11-bit stick axes and
//   five button levels. cmd_out carries exactly one result per poll: gimbal
//   update flag with clamped roll/pitch, zoom update flag with zoom word, and
//   save / stabilize pulses. Registers must be written through cfg_we /
//   cfg_idx / cfg_wdata only while no poll is in flight; the block itself does
//   not enforce this. A poll passes the input stage and the output register
//   before cmd_out.valid rises. One poll is taken every cycle while cmd_out
//   accepts results; the state word (angles, zoom level, previous buttons) lives
//   in a one-entry RAM with registered read, and the write of one poll is
//   forwarded to the next so polls follow back to back. The axis step comes from
//   a curve ROM built at elaboration, read when the poll is taken. When cmd_out
//   stalls the result holds in the output register and one more poll can wait
//   in the input stage; after that stick_in.ready drops. Reset clears the
//   registers to their defaults, angles to 3000, zoom level to 1 and the
//   previous buttons to zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stick_to_gimbal_command_mapper #(
	parameter int GAIN            = sgcm_pkg::GAIN_DEF,
	parameter int AXIS_FULL_SCALE = sgcm_pkg::AXIS_FULL_SCALE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sgcm_in_if.sink                         stick_in,
	sgcm_out_if.source                      cmd_out,
	input  logic                            cfg_we,
	input  logic [sgcm_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sgcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sgcm_pkg::*;

	localparam int STEP_MAX  = int'(CURVE_SCALE) * GAIN;
	localparam int STEP_W    = $clog2(STEP_MAX + 1);
	localparam int ROM_MAX   = (AXIS_FULL_SCALE < AXIS_MAG_MAX) ? AXIS_FULL_SCALE
		: AXIS_MAG_MAX;
	localparam int ROM_DEPTH = ROM_MAX + 1;
	localparam int IDX_W     = $clog2(ROM_DEPTH);
	localparam int EXT_W     = ((STEP_W > ANGLE_W) ? STEP_W : ANGLE_W) + 2;
	localparam int ST_W      = $bits(state_t);

	// ---------------- configuration registers ----------------
	logic [DZ_W-1:0]    deadzone_q;
	logic [ANGLE_W-1:0] center_q;
	logic [ANGLE_W-1:0] roll_min_q;
	logic [ANGLE_W-1:0] roll_max_q;
	logic [ANGLE_W-1:0] pitch_min_q;
	logic [ANGLE_W-1:0] pitch_max_q;
	logic [ZOOM_W-1:0]  zoom_min_q;
	logic [ZOOM_W-1:0]  zoom_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q  <= DEADZONE_RST;
			center_q    <= CENTER_RST;
			roll_min_q  <= ANGLE_LO_RST;
			roll_max_q  <= ANGLE_HI_RST;
			pitch_min_q <= ANGLE_LO_RST;
			pitch_max_q <= ANGLE_HI_RST;
			zoom_min_q  <= ZOOM_MIN_RST;
			zoom_max_q  <= ZOOM_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_DEADZONE:     deadzone_q  <= cfg_wdata[DZ_W-1:0];
				CFG_CENTER_ANGLE: center_q    <= cfg_wdata[ANGLE_W-1:0];
				CFG_ROLL_MIN:     roll_min_q  <= cfg_wdata[ANGLE_W-1:0];
				CFG_ROLL_MAX:     roll_max_q  <= cfg_wdata[ANGLE_W-1:0];
				CFG_PITCH_MIN:    pitch_min_q <= cfg_wdata[ANGLE_W-1:0];
				CFG_PITCH_MAX:    pitch_max_q <= cfg_wdata[ANGLE_W-1:0];
				CFG_ZOOM_MIN:     zoom_min_q  <= cfg_wdata[ZOOM_W-1:0];
				CFG_ZOOM_MAX:     zoom_max_q  <= cfg_wdata[ZOOM_W-1:0];
			endcase
		end
	end

	// ---------------- curve ROM ----------------
	logic [STEP_W-1:0] curve_rom [ROM_DEPTH];

	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_curve
		localparam longint unsigned X    = (longint'(i) * LN4_Q28)
			/ longint'(AXIS_FULL_SCALE);
		localparam longint unsigned SUM  = curve_sum_f(X);
		localparam longint unsigned STEP = (SUM * CURVE_SCALE * longint'(GAIN))
			/ (3 * ONE_Q28);
		assign curve_rom[i] = STEP_W'(STEP);
	end

	function automatic logic [AXIS_W-1:0] axis_mag_f(logic [AXIS_W-1:0] a);
		return a[AXIS_W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic [IDX_W-1:0] rom_idx_f(logic [AXIS_W-1:0] mag);
		return (mag > AXIS_W'(ROM_MAX)) ? IDX_W'(ROM_MAX) : mag[IDX_W-1:0];
	endfunction

	// saturate to the 16-bit range, then max, then min (min wins)
	function automatic logic [ANGLE_W-1:0] limit_f(logic signed [EXT_W-1:0] v,
			logic [ANGLE_W-1:0] lo, logic [ANGLE_W-1:0] hi);
		logic [ANGLE_W-1:0] u;
		if (v < 0) begin
			u = '0;
		end else if (v > signed'(EXT_W'({ANGLE_W{1'b1}}))) begin
			u = '1;
		end else begin
			u = v[ANGLE_W-1:0];
		end
		if (u > hi) u = hi;
		if (u < lo) u = lo;
		return u;
	endfunction

	// ---------------- input stage ----------------
	logic              in_xfer;
	logic              advance;
	logic              wr;
	logic [AXIS_W-1:0] mag_x;
	logic [AXIS_W-1:0] mag_y;

	logic              valid_s1;
	logic [STEP_W-1:0] step_x_s1;
	logic [STEP_W-1:0] step_y_s1;
	logic              neg_x_s1;
	logic              neg_y_s1;
	logic              move_s1;
	logic [BTN_W-1:0]  btn_s1;

	logic out_valid_q;

	assign advance        = !out_valid_q || cmd_out.ready;
	assign stick_in.ready = !valid_s1 || advance;
	assign in_xfer        = stick_in.valid && stick_in.ready;
	assign wr             = valid_s1 && advance;

	assign mag_x = axis_mag_f(stick_in.stick_x);
	assign mag_y = axis_mag_f(stick_in.stick_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stick_in.ready) begin
			valid_s1 <= stick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			step_x_s1 <= curve_rom[rom_idx_f(mag_x)];
			step_y_s1 <= curve_rom[rom_idx_f(mag_y)];
			neg_x_s1  <= stick_in.stick_x[AXIS_W-1];
			neg_y_s1  <= stick_in.stick_y[AXIS_W-1];
			move_s1   <= (mag_x > {1'b0, deadzone_q}) || (mag_y > {1'b0, deadzone_q});
			btn_s1    <= {stick_in.btn_center, stick_in.btn_zoom_up,
				stick_in.btn_zoom_down, stick_in.btn_stabilize, stick_in.btn_save};
		end
	end

	// ---------------- state store with forwarding ----------------
	state_t ram_rd;
	state_t nxt_state;
	state_t cur_state;
	state_t fwd_data_q;
	logic   fwd_valid_q;
	logic   written_q;

	sgcm_ram #(
		.WIDTH (ST_W),
		.DEPTH (1)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr),
		.wr_addr ('0),
		.wr_data (nxt_state),
		.rd_addr ('0),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			written_q   <= 1'b0;
		end else begin
			fwd_valid_q <= wr;
			if (wr) written_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) fwd_data_q <= nxt_state;
	end

	// last cycle's write is not yet visible in the read data
	always_comb begin
		if (fwd_valid_q) begin
			cur_state = fwd_data_q;
		end else if (written_q) begin
			cur_state = ram_rd;
		end else begin
			cur_state = STATE_RST;
		end
	end

	// ---------------- update logic ----------------
	logic [BTN_W-1:0]         rise;
	logic signed [EXT_W-1:0]  roll_old;
	logic signed [EXT_W-1:0]  pitch_old;
	logic signed [EXT_W-1:0]  step_x_ext;
	logic signed [EXT_W-1:0]  step_y_ext;
	logic signed [EXT_W-1:0]  roll_new;
	logic signed [EXT_W-1:0]  pitch_new;
	logic                     gupd;
	logic                     zdown;
	logic                     zup;
	logic                     zupd;
	logic [ZOOM_W-1:0]        lvl;
	logic [ZOOM_CODE_W-1:0]   zcode;

	always_comb begin
		rise       = btn_s1 & ~cur_state.btn;
		roll_old   = signed'(EXT_W'(cur_state.roll));
		pitch_old  = signed'(EXT_W'(cur_state.pitch));
		step_x_ext = signed'(EXT_W'(step_x_s1));
		step_y_ext = signed'(EXT_W'(step_y_s1));
		roll_new   = roll_old;
		pitch_new  = pitch_old;
		if (move_s1) begin
			// roll moves against the X axis, pitch with the Y axis
			roll_new  = neg_x_s1 ? roll_old + step_x_ext : roll_old - step_x_ext;
			pitch_new = neg_y_s1 ? pitch_old - step_y_ext : pitch_old + step_y_ext;
		end
		if (rise[BTN_CENTER]) begin
			roll_new  = signed'(EXT_W'(center_q));
			pitch_new = signed'(EXT_W'(center_q));
		end
		gupd = (roll_new != roll_old) || (pitch_new != pitch_old);

		zdown = rise[BTN_ZOOM_DOWN];
		zup   = rise[BTN_ZOOM_UP];
		zupd  = zdown != zup;
		lvl   = cur_state.zoom;
		if (zupd) begin
			if (zdown) begin
				if (lvl > zoom_min_q) lvl = lvl - 1'b1;
			end else begin
				if (lvl < zoom_max_q) lvl = lvl + 1'b1;
			end
			if (lvl > zoom_max_q) lvl = zoom_max_q;
			if (lvl < zoom_min_q) lvl = zoom_min_q;
		end
		zcode = zupd ? zoom_word_f(lvl) : '0;

		nxt_state.roll  = gupd ? limit_f(roll_new, roll_min_q, roll_max_q)
			: cur_state.roll;
		nxt_state.pitch = gupd ? limit_f(pitch_new, pitch_min_q, pitch_max_q)
			: cur_state.pitch;
		nxt_state.zoom  = lvl;
		nxt_state.btn   = btn_s1;
	end

	// ---------------- output register ----------------
	logic                   gupd_q;
	logic [ANGLE_W-1:0]     roll_q;
	logic [ANGLE_W-1:0]     pitch_q;
	logic                   zupd_q;
	logic [ZOOM_CODE_W-1:0] zcode_q;
	logic                   save_q;
	logic                   stab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			gupd_q  <= gupd;
			roll_q  <= nxt_state.roll;
			pitch_q <= nxt_state.pitch;
			zupd_q  <= zupd;
			zcode_q <= zcode;
			save_q  <= rise[BTN_SAVE];
			stab_q  <= rise[BTN_STABILIZE];
		end
	end

	assign cmd_out.valid           = out_valid_q;
	assign cmd_out.gimbal_update   = gupd_q;
	assign cmd_out.roll_cmd        = roll_q;
	assign cmd_out.pitch_cmd       = pitch_q;
	assign cmd_out.zoom_update     = zupd_q;
	assign cmd_out.zoom_code       = zcode_q;
	assign cmd_out.save_pulse      = save_q;
	assign cmd_out.stabilize_pulse = stab_q;

`ifndef NO_ASSERTIONS
	// RAM read data must match the last write once forwarding is off
	a_fwd_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(written_q && !fwd_valid_q) |-> (ram_rd == fwd_data_q))
		else $error("state RAM read disagrees with last written state");

	a_roll_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gupd_q && roll_min_q <= roll_max_q)
			|-> (roll_q >= roll_min_q && roll_q <= roll_max_q))
		else $error("roll command outside its limits");

	a_pitch_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gupd_q && pitch_min_q <= pitch_max_q)
			|-> (pitch_q >= pitch_min_q && pitch_q <= pitch_max_q))
		else $error("pitch command outside its limits");

	a_zoom_level: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && zupd && zoom_min_q <= zoom_max_q)
			|=> (fwd_data_q.zoom >= zoom_min_q && fwd_data_q.zoom <= zoom_max_q))
		else $error("zoom level left its limits");

	a_zoom_code_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !zupd_q) |-> (zcode_q == '0))
		else $error("zoom word present without a zoom update");
`endif

endmodule

`default_nettype wire

// ===== sv/sgcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sgcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the contents before a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire
